// File: rtl/tfcd_pkg.sv
// types and constants shared by the class-selective byte queue
`timescale 1ns / 1ps

package tfcd_pkg;

    typedef enum logic [1:0] {
        OP_ENQ     = 2'd0,
        OP_DEQ_ANY = 2'd1,
        OP_DEQ_CAT = 2'd2,
        OP_DEQ_DOG = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    localparam logic [7:0] BYTE_CAT  = 8'd67;
    localparam logic [7:0] BYTE_DOG  = 8'd68;
    localparam logic [7:0] BYTE_NONE = 8'd69;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] item;
    } in_item_t;

    typedef struct packed {
        logic [7:0] value;
        logic [1:0] status;
        logic [4:0] occupancy;
    } out_item_t;

    typedef struct packed {
        logic       any;
        logic [7:0] want;
        logic [7:0] item;
        logic       load;
        logic       shift;
    } cell_ctrl_t;

endpackage

// File: rtl/tfcd_cell.sv
// one queue slot: match detection, priority hand-off and shift-down compaction
`timescale 1ns / 1ps

module tfcd_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic                clk,
    input  tfcd_pkg::cell_ctrl_t ctrl,
    input  logic [CW-1:0]       count,
    input  logic                hit_in,
    output logic                hit_out,
    input  logic [7:0]          value_in,
    output logic [7:0]          value_out,
    input  logic [7:0]          next_data,
    output logic [7:0]          data
);
    import tfcd_pkg::*;

    localparam logic [CW-1:0] POS = CW'(IDX);

    logic [7:0] data_reg;
    logic [7:0] data_next;
    logic       live;
    logic       match;
    logic       first;

    // slot holds an entry when it lies below the fill count
    assign live      = POS < count;
    assign match     = live && (ctrl.any || (data_reg == ctrl.want));
    assign first     = match && !hit_in;
    assign hit_out   = hit_in || match;
    assign value_out = value_in | (first ? data_reg : 8'd0);
    assign data      = data_reg;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.shift && hit_out)
        begin
            data_next = next_data;
        end
        else if (ctrl.load && (count == POS))
        begin
            data_next = ctrl.item;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// File: rtl/tagged_fifo_class_dequeue.sv
// top level of the class-selective byte queue built from a row of slot cells
//
// usage
//   in_valid/in_ready carry one operation: op and item. op selects enqueue,
//   dequeue oldest, dequeue oldest 'C' or dequeue oldest 'D'.
//   out_valid/out_ready carry one result per operation: removed value,
//   status and occupancy after the operation.
//   an operation is finished in the cycle of its transfer; its result is
//   registered and shown in the next cycle, and one operation can be
//   taken every cycle while the output is drained.
//   the oldest-match search runs as a priority hand-off along the cells and
//   removal shifts every later slot down by one in the same cycle.
//   if the receiver stalls, the held result stays put and in_ready drops
//   until that result is taken.
//   reset empties the queue and clears out_valid; slot contents are not
//   cleared and are never read before being written.
`timescale 1ns / 1ps

module tagged_fifo_class_dequeue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tfcd_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tfcd_pkg::out_item_t  out_data
);
    import tfcd_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    out_item_t     out_data_reg;
    out_item_t     out_data_next;

    logic          in_fire;
    logic          is_enq;
    logic          full;
    logic          found;
    cell_ctrl_t    ctrl;

    logic [QUEUE_DEPTH:0]       hit_chain;
    logic [QUEUE_DEPTH:0][7:0]  value_chain;
    logic [QUEUE_DEPTH:0][7:0]  data_chain;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign is_enq    = (in_data.op == OP_ENQ);
    assign full      = (count_reg == DEPTH_C);
    assign found     = hit_chain[QUEUE_DEPTH];
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign hit_chain[0]              = 1'b0;
    assign value_chain[0]            = 8'd0;
    assign data_chain[QUEUE_DEPTH]   = 8'd0;

    always_comb
    begin
        ctrl.any   = (in_data.op == OP_DEQ_ANY);
        ctrl.want  = (in_data.op == OP_DEQ_CAT) ? BYTE_CAT : BYTE_DOG;
        ctrl.item  = in_data.item;
        ctrl.load  = in_fire && is_enq && !full;
        ctrl.shift = in_fire && !is_enq && found;
    end

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        tfcd_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .count     (count_reg),
            .hit_in    (hit_chain[i]),
            .hit_out   (hit_chain[i+1]),
            .value_in  (value_chain[i]),
            .value_out (value_chain[i+1]),
            .next_data (data_chain[i+1]),
            .data      (data_chain[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.load)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctrl.shift)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (in_fire)
        begin
            out_valid_next = 1'b1;
            out_data_next.occupancy = 5'(count_next);
            if (is_enq)
            begin
                out_data_next.value  = 8'd0;
                out_data_next.status = full ? ST_FULL : ST_OK;
            end
            else if (found)
            begin
                out_data_next.value  = value_chain[QUEUE_DEPTH];
                out_data_next.status = ST_OK;
            end
            else
            begin
                out_data_next.value  = BYTE_NONE;
                out_data_next.status = ST_MISS;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("fill count above depth");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && is_enq && full |=> out_data_reg.status == ST_FULL)
        else $error("dropped enqueue not flagged");

    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.shift |=> count_reg == $past(count_reg) - CW'(1))
        else $error("removal did not shrink the queue");

    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> $stable(count_reg))
        else $error("fill count moved without a transfer");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("transfer produced no result");

endmodule

// File: tb/tagged_fifo_class_dequeue_tb.sv
// self-checking testbench for the class-selective byte queue
`timescale 1ns / 1ps

module tagged_fifo_class_dequeue_tb;

    import tfcd_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int RANDOM_OPS = 500;
    localparam int CALM_TAIL = 100;

    typedef struct {
        in_item_t  stim;
        bit        typed;
        out_item_t want;
    } op_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    logic [7:0] held_bytes[$];
    out_item_t  pending_results[$];
    op_row_t    directed_rows[$];
    int         mismatches = 0;
    bit         in_idle_on = 1'b0;
    bit         out_stall_on = 1'b0;

    tagged_fifo_class_dequeue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("mismatch in %s: got %0d expected %0d at %0t", what, got, want, $time);
    endtask

    // applies one operation to the shadow queue and returns its result
    function automatic out_item_t apply_queue_op(input in_item_t t);
        out_item_t  r;
        op_t        op;
        logic [7:0] want;
        int         idx;
        r = '0;
        r.status = ST_OK;
        op = op_t'(t.op);
        if (op == OP_ENQ)
        begin
            if (held_bytes.size() < QUEUE_DEPTH)
                held_bytes.push_back(t.item);
            else
                r.status = ST_FULL;
        end
        else if (held_bytes.size() == 0)
        begin
            r.value = BYTE_NONE;
            r.status = ST_MISS;
        end
        else if (op == OP_DEQ_ANY)
        begin
            r.value = held_bytes.pop_front();
        end
        else
        begin
            want = (op == OP_DEQ_CAT) ? BYTE_CAT : BYTE_DOG;
            idx = -1;
            for (int i = 0; i < held_bytes.size(); i++)
                if (idx < 0 && held_bytes[i] == want)
                    idx = i;
            if (idx >= 0)
            begin
                r.value = held_bytes[idx];
                held_bytes.delete(idx);
            end
            else
            begin
                r.value = BYTE_NONE;
                r.status = ST_MISS;
            end
        end
        r.occupancy = 5'(held_bytes.size());
        return r;
    endfunction

    function automatic void add_row(input op_t op, input logic [7:0] item,
                                    input bit typed = 1'b0, input logic [7:0] v = '0,
                                    input status_t s = ST_OK, input logic [4:0] occ = '0);
        op_row_t row;
        row.stim.op = op;
        row.stim.item = item;
        row.typed = typed;
        row.want.value = v;
        row.want.status = s;
        row.want.occupancy = occ;
        directed_rows.push_back(row);
    endfunction

    task automatic send_op(input in_item_t t, input bit typed, input out_item_t want);
        out_item_t predicted;
        if (in_idle_on && $urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 5))
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data <= t;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = apply_queue_op(t);
        pending_results.push_back(typed ? want : predicted);
    endtask

    always @(negedge clk)
    begin : drive_out_ready
        int stall_left;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else if (out_stall_on && $urandom_range(0, 4) == 0)
        begin
            out_ready <= 1'b0;
            stall_left = $urandom_range(1, 5) - 1;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_results
        out_item_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result value", out_data.value, -1);
            end
            else
            begin
                e = pending_results.pop_front();
                if (out_data.value !== e.value)
                    report_mismatch("value", out_data.value, e.value);
                if (out_data.status !== e.status)
                    report_mismatch("status", out_data.status, e.status);
                if (out_data.occupancy !== e.occupancy)
                    report_mismatch("occupancy", out_data.occupancy, e.occupancy);
            end
        end
    end

    initial
    begin : stimulus
        in_item_t  t;
        out_item_t none;
        int        sent;
        int        seg_len;
        int        enq_pct;
        int        pick;
        none = '0;

        add_row(OP_DEQ_ANY, 8'h00, 1'b1, BYTE_NONE, ST_MISS, 5'd0);
        add_row(OP_DEQ_CAT, 8'hFF, 1'b1, BYTE_NONE, ST_MISS, 5'd0);
        add_row(OP_DEQ_DOG, 8'h5A, 1'b1, BYTE_NONE, ST_MISS, 5'd0);
        add_row(OP_ENQ, 8'h00, 1'b1, 8'h00, ST_OK, 5'd1);
        add_row(OP_ENQ, 8'hFF, 1'b1, 8'h00, ST_OK, 5'd2);
        add_row(OP_DEQ_CAT, BYTE_CAT, 1'b1, BYTE_NONE, ST_MISS, 5'd2);
        add_row(OP_DEQ_DOG, BYTE_DOG, 1'b1, BYTE_NONE, ST_MISS, 5'd2);
        add_row(OP_ENQ, BYTE_DOG, 1'b1, 8'h00, ST_OK, 5'd3);
        add_row(OP_ENQ, 8'h42, 1'b1, 8'h00, ST_OK, 5'd4);
        add_row(OP_ENQ, BYTE_CAT, 1'b1, 8'h00, ST_OK, 5'd5);
        add_row(OP_ENQ, BYTE_DOG, 1'b1, 8'h00, ST_OK, 5'd6);
        add_row(OP_ENQ, BYTE_NONE, 1'b1, 8'h00, ST_OK, 5'd7);
        add_row(OP_ENQ, 8'h55, 1'b1, 8'h00, ST_OK, 5'd8);
        add_row(OP_ENQ, 8'hAA, 1'b1, 8'h00, ST_OK, 5'd9);
        add_row(OP_ENQ, BYTE_CAT, 1'b1, 8'h00, ST_OK, 5'd10);
        add_row(OP_ENQ, 8'h01, 1'b1, 8'h00, ST_OK, 5'd11);
        add_row(OP_ENQ, 8'h80, 1'b1, 8'h00, ST_OK, 5'd12);
        add_row(OP_ENQ, 8'h7F, 1'b1, 8'h00, ST_OK, 5'd13);
        add_row(OP_ENQ, BYTE_DOG, 1'b1, 8'h00, ST_OK, 5'd14);
        add_row(OP_ENQ, BYTE_CAT, 1'b1, 8'h00, ST_OK, 5'd15);
        add_row(OP_ENQ, 8'hFE, 1'b1, 8'h00, ST_OK, 5'd16);
        add_row(OP_ENQ, 8'h11, 1'b1, 8'h00, ST_FULL, 5'd16);
        add_row(OP_DEQ_DOG, 8'h00);
        add_row(OP_DEQ_CAT, 8'hFF);
        add_row(OP_DEQ_ANY, 8'h33);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_op(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);

        // segments lean towards filling, balance or draining so full and empty recur
        sent = 0;
        while (sent < RANDOM_OPS)
        begin
            seg_len = $urandom_range(10, 40);
            case ($urandom_range(0, 2))
                0: enq_pct = 25;
                1: enq_pct = 50;
                default: enq_pct = 85;
            endcase
            in_idle_on = ($urandom_range(0, 2) != 0);
            out_stall_on = ($urandom_range(0, 2) != 0);
            if (sent >= RANDOM_OPS - CALM_TAIL)
            begin
                in_idle_on = 1'b0;
                out_stall_on = 1'b0;
            end
            repeat (seg_len)
            begin
                if ($urandom_range(0, 99) < enq_pct)
                begin
                    t.op = OP_ENQ;
                    pick = $urandom_range(0, 9);
                    if (pick < 4)
                        t.item = BYTE_CAT;
                    else if (pick < 7)
                        t.item = BYTE_DOG;
                    else
                        t.item = 8'($urandom_range(0, 255));
                end
                else
                begin
                    t.op = 2'($urandom_range(OP_DEQ_ANY, OP_DEQ_DOG));
                    t.item = 8'($urandom_range(0, 255));
                end
                send_op(t, 1'b0, none);
                sent++;
            end
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #1ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
